>>> rtl/core/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared codes, status byte constants, state and result types.
// ----------------------------------------------------------------------------
package mbsp_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_MSG      = 3'd0;
	localparam logic [2:0] KIND_SX_START = 3'd1;
	localparam logic [2:0] KIND_SX_DATA  = 3'd2;
	localparam logic [2:0] KIND_SX_END   = 3'd3;
	localparam logic [2:0] KIND_SX_ABORT = 3'd4;
	localparam logic [2:0] KIND_ERROR    = 3'd5;

	// Error codes.
	localparam logic [1:0] ERR_END_NO_START = 2'd0;
	localparam logic [1:0] ERR_ORPHAN       = 2'd1;
	localparam logic [1:0] ERR_UNEXPECTED   = 2'd2;

	// Status bytes and range limits.
	localparam logic [7:0] SB_STATUS_MIN = 8'h80;
	localparam logic [7:0] SB_TWO_MAX    = 8'hBF;
	localparam logic [7:0] SB_ONE_MIN    = 8'hC0;
	localparam logic [7:0] SB_ONE_MAX    = 8'hDF;
	localparam logic [7:0] SB_BEND_MIN   = 8'hE0;
	localparam logic [7:0] SB_CHAN_MAX   = 8'hEF;
	localparam logic [7:0] SB_SX_START   = 8'hF0;
	localparam logic [7:0] SB_MTC        = 8'hF1;
	localparam logic [7:0] SB_SONG_POS   = 8'hF2;
	localparam logic [7:0] SB_SONG_SEL   = 8'hF3;
	localparam logic [7:0] SB_TUNE_REQ   = 8'hF6;
	localparam logic [7:0] SB_SX_END     = 8'hF7;
	localparam logic [7:0] SB_RT_MIN     = 8'hF8;

	typedef struct packed {
		logic [7:0] current_status;
		logic [7:0] run_status;
		logic [6:0] first_data;
		logic [6:0] second_data;
		logic [1:0] data_seen;
		logic       in_sysex;
	} state_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] status_or_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
		logic [1:0] data_length;
		logic [1:0] error_code;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		state_t     next_state;
	} decode_t;

	// Number of data bytes that completes a message with this status.
	function automatic logic [1:0] needed_data(input logic [7:0] st);
		logic [1:0] n;
		n = 2'd0;
		if (st >= SB_STATUS_MIN && st <= SB_TWO_MAX) n = 2'd2;
		else if (st >= SB_ONE_MIN && st <= SB_ONE_MAX) n = 2'd1;
		else if (st >= SB_BEND_MIN && st <= SB_CHAN_MAX) n = 2'd2;
		else if (st == SB_SONG_POS) n = 2'd2;
		else if (st == SB_MTC || st == SB_SONG_SEL) n = 2'd1;
		return n;
	endfunction

endpackage

>>> rtl/core/mbsp_byte_if.sv
// ----------------------------------------------------------------------------
// MIDI byte channel
// Valid/ready channel carrying one raw MIDI byte and its timestamp.
// ----------------------------------------------------------------------------
interface mbsp_byte_if;
	logic              valid;
	logic              ready;
	logic [7:0]        stream_byte;
	logic signed [63:0] time_stamp;

	modport source (output valid, output stream_byte, output time_stamp, input ready);
	modport sink (input valid, input stream_byte, input time_stamp, output ready);
endinterface

>>> rtl/core/mbsp_event_if.sv
// ----------------------------------------------------------------------------
// MIDI parser event channel
// Valid/ready channel carrying one parsed message or event.
// ----------------------------------------------------------------------------
interface mbsp_event_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic [7:0]         status_or_byte;
	logic [6:0]         data_one;
	logic [6:0]         data_two;
	logic [1:0]         data_length;
	logic [1:0]         error_code;
	logic signed [63:0] time_out;
	logic               last_of_run;

	modport source (output valid, output event_kind, output status_or_byte,
		output data_one, output data_two, output data_length, output error_code,
		output time_out, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input status_or_byte,
		input data_one, input data_two, input data_length, input error_code,
		input time_out, input last_of_run, output ready);
endinterface

>>> rtl/core/mbsp_decode.sv
// ----------------------------------------------------------------------------
// MIDI byte decoder
// Combinational parse step: from the parse state and one byte, the first
// result, the number of results and the next parse state.
// ----------------------------------------------------------------------------
module mbsp_decode (
	input  mbsp_pkg::state_t  st,
	input  logic [7:0]        stream_byte,
	output mbsp_pkg::decode_t dec
);
	import mbsp_pkg::*;

	logic [7:0] cur_sel;
	logic       orphan;
	logic       takes_data;
	logic [2:0] cnt;

	always_comb begin
		cur_sel    = st.current_status[7] ? st.current_status : st.run_status;
		orphan     = !st.current_status[7] && (st.run_status == 8'h00);
		takes_data = (cur_sel >= SB_STATUS_MIN && cur_sel <= SB_CHAN_MAX) ||
		             (cur_sel >= SB_MTC && cur_sel <= SB_SONG_SEL);
		cnt        = {1'b0, st.data_seen} + 3'd1;

		dec            = '0;
		dec.next_state = st;
		dec.first.event_kind = KIND_MSG;

		if (stream_byte >= SB_RT_MIN) begin
			dec.count = 2'd1;
			dec.first.status_or_byte = stream_byte;
		end else if (stream_byte == SB_SX_START) begin
			dec.next_state.current_status = stream_byte;
			dec.next_state.run_status     = 8'h00;
			dec.next_state.data_seen      = 2'd0;
			dec.next_state.in_sysex       = 1'b1;
			dec.count = 2'd1;
			dec.first.event_kind     = KIND_SX_START;
			dec.first.status_or_byte = stream_byte;
		end else if (stream_byte == SB_SX_END) begin
			dec.count = 2'd1;
			if (!st.in_sysex) begin
				dec.next_state = '0;
				dec.first.event_kind = KIND_ERROR;
				dec.first.error_code = ERR_END_NO_START;
			end else begin
				dec.next_state.current_status = 8'h00;
				dec.next_state.run_status     = 8'h00;
				dec.next_state.data_seen      = 2'd0;
				dec.next_state.in_sysex       = 1'b0;
				dec.first.event_kind     = KIND_SX_END;
				dec.first.status_or_byte = stream_byte;
			end
		end else if (stream_byte[7]) begin
			// A status byte inside SysEx aborts it; tune request then also
			// reports itself as a second result.
			if (st.in_sysex) begin
				dec.first.event_kind = KIND_SX_ABORT;
				dec.count = (stream_byte == SB_TUNE_REQ) ? 2'd2 : 2'd1;
			end else begin
				dec.count = (stream_byte == SB_TUNE_REQ) ? 2'd1 : 2'd0;
			end
			dec.first.status_or_byte = stream_byte;
			dec.next_state.current_status = stream_byte;
			dec.next_state.run_status =
				(stream_byte <= SB_CHAN_MAX) ? stream_byte : 8'h00;
			dec.next_state.data_seen = 2'd0;
			dec.next_state.in_sysex  = 1'b0;
		end else if (st.in_sysex) begin
			dec.count = 2'd1;
			dec.first.event_kind     = KIND_SX_DATA;
			dec.first.status_or_byte = stream_byte;
		end else if (orphan) begin
			dec.next_state = '0;
			dec.count = 2'd1;
			dec.first.event_kind = KIND_ERROR;
			dec.first.error_code = ERR_ORPHAN;
		end else if (takes_data) begin
			if (cnt == 3'd1) begin
				dec.next_state.first_data = stream_byte[6:0];
			end else if (cnt == 3'd2) begin
				dec.next_state.second_data = stream_byte[6:0];
			end
			if (cnt > 3'd2) begin
				dec.next_state = '0;
				dec.count = 2'd1;
				dec.first.event_kind = KIND_ERROR;
				dec.first.error_code = ERR_UNEXPECTED;
			end else begin
				dec.next_state.data_seen = cnt[1:0];
				if (cnt == {1'b0, needed_data(cur_sel)}) begin
					dec.count = 2'd1;
					dec.first.status_or_byte = cur_sel;
					dec.first.data_one       = dec.next_state.first_data;
					dec.first.data_two       = dec.next_state.second_data;
					dec.first.data_length    = cnt[1:0];
					dec.next_state.current_status = 8'h00;
					dec.next_state.data_seen      = 2'd0;
					dec.next_state.first_data     = 7'h00;
					dec.next_state.second_data    = 7'h00;
				end
			end
		end
		// Data bytes after a status without data are dropped silently.
	end

endmodule

>>> rtl/core/midi_byte_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser unit
// Running-status MIDI parser with SysEx event reporting and error results.
// ----------------------------------------------------------------------------
// The parser takes one MIDI byte per clock cycle unless output stalls or a
// second result is pending. Each item passes an input register, one decode
// step against the parse state, and a result register. A byte that causes no
// result retires without waiting for the result register. The only byte that
// causes two results is a tune request arriving during SysEx (abort, then the
// message); it holds the decode stage until both are loaded, as the result
// register holds one result at a time. Timestamps are copied unchanged.
module midi_byte_stream_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	mbsp_byte_if.sink           stream,
	mbsp_event_if.source        events
);
	import mbsp_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic signed [63:0] time_s1;
	logic               pend_q;
	state_t             state_q;

	logic               out_valid_q;
	result_t            result_q;
	logic signed [63:0] time_q;
	logic               last_q;

	decode_t            dec;
	logic               can_load;
	logic               load;
	logic               consume;
	logic               state_we;
	logic               pend_set;
	result_t            load_res;
	logic               load_last;

	mbsp_decode u_decode (
		.st          (state_q),
		.stream_byte (byte_s1),
		.dec         (dec)
	);

	always_comb begin
		can_load  = !out_valid_q || events.ready;
		load      = 1'b0;
		consume   = 1'b0;
		state_we  = 1'b0;
		pend_set  = 1'b0;
		load_res  = dec.first;
		load_last = 1'b1;
		if (valid_s1) begin
			if (pend_q) begin
				// Second result of a tune request that aborted SysEx.
				load_res = '0;
				load_res.event_kind     = KIND_MSG;
				load_res.status_or_byte = SB_TUNE_REQ;
				if (can_load) begin
					load    = 1'b1;
					consume = 1'b1;
				end
			end else begin
				case (dec.count)
					2'd0: begin
						consume  = 1'b1;
						state_we = 1'b1;
					end
					2'd1: begin
						if (can_load) begin
							load     = 1'b1;
							consume  = 1'b1;
							state_we = 1'b1;
						end
					end
					default: begin
						load_last = 1'b0;
						if (can_load) begin
							load     = 1'b1;
							state_we = 1'b1;
							pend_set = 1'b1;
						end
					end
				endcase
			end
		end
	end

	assign stream.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.stream_byte;
			time_s1 <= stream.time_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			state_q <= '0;
		end else begin
			if (consume) begin
				pend_q <= 1'b0;
			end else if (pend_set) begin
				pend_q <= 1'b1;
			end
			if (state_we) begin
				state_q <= dec.next_state;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= load_res;
			time_q   <= time_s1;
			last_q   <= load_last;
		end
	end

	assign events.valid          = out_valid_q;
	assign events.event_kind     = result_q.event_kind;
	assign events.status_or_byte = result_q.status_or_byte;
	assign events.data_one       = result_q.data_one;
	assign events.data_two       = result_q.data_two;
	assign events.data_length    = result_q.data_length;
	assign events.error_code     = result_q.error_code;
	assign events.time_out       = time_q;
	assign events.last_of_run    = last_q;

	// A pending second result always belongs to a byte still held in stage one.
	a_pend_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> valid_s1)
		else $error("pending second result without an item in stage one");

	// The first half of a two-result item leaves the tune request as status.
	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q.current_status == SB_TUNE_REQ && !state_q.in_sysex))
		else $error("parse state wrong while second result is pending");

	// Only a SysEx abort is ever followed by a second result of the same item.
	a_not_last_is_abort: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (result_q.event_kind == KIND_SX_ABORT))
		else $error("non-final result that is not a SysEx abort");

	// Running status is dropped whenever SysEx is entered.
	a_sysex_no_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_sysex |-> (state_q.run_status == 8'h00))
		else $error("running status kept inside SysEx");

	// A completed message clears the count, so it never reaches three.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.data_seen != 2'd3)
		else $error("data byte count out of range");

endmodule

>>> dv/tb_midi_byte_stream_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser unit testbench
// Drives directed and random MIDI byte streams with random timestamps, gaps
// and output stalls, predicts every parsed message and SysEx/error event
// from a running-status model, and compares the events field by field.
// ----------------------------------------------------------------------------
module tb_midi_byte_stream_parser_unit;
	import mbsp_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int IDLE_LIMIT   = 2000;

	typedef struct {
		logic [7:0]  value;
		logic [63:0] stamp;
		int unsigned gap;
		bit          drain;
	} byte_item_t;

	typedef struct packed {
		result_t     body;
		logic [63:0] stamp;
		logic        last;
	} parsed_event_t;

	logic clk;
	logic arst_n;

	mbsp_byte_if  byte_ch ();
	mbsp_event_if event_ch ();

	midi_byte_stream_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.events (event_ch)
	);

	byte_item_t    byte_items[$];
	parsed_event_t pending_events[$];
	parsed_event_t byte_events[$];
	byte_item_t    next_item;
	parsed_event_t want;
	logic [7:0]    opening[$];

	// Parser state as the stream has left it.
	logic [7:0] cur_status;
	logic [7:0] run_status;
	logic [6:0] data_a;
	logic [6:0] data_b;
	logic [1:0] seen_count;
	logic       sysex_open;

	int          predicted_n;
	int          checked_n;
	int          made_n;
	int          failures;
	int unsigned gap_cnt;
	int unsigned stall_cnt;
	int unsigned stall;
	int unsigned idle_cycles;
	int unsigned cycle_n;

	function automatic int msg_needed(input logic [7:0] st);
		if (st >= 8'h80 && st <= 8'hBF) return 2;
		if (st >= 8'hC0 && st <= 8'hDF) return 1;
		if (st >= 8'hE0 && st <= 8'hEF) return 2;
		if (st == SB_SONG_POS) return 2;
		if (st == SB_MTC || st == SB_SONG_SEL) return 1;
		return 0;
	endfunction

	function automatic void clear_parse();
		cur_status = '0;
		run_status = '0;
		data_a = '0;
		data_b = '0;
		seen_count = '0;
		sysex_open = 1'b0;
	endfunction

	function automatic void emit(input logic [2:0] kind, input logic [7:0] sb,
		input logic [6:0] d1, input logic [6:0] d2, input logic [1:0] len,
		input logic [1:0] err, input logic [63:0] stamp);
		parsed_event_t ev;
		ev.body.event_kind = kind;
		ev.body.status_or_byte = sb;
		ev.body.data_one = d1;
		ev.body.data_two = d2;
		ev.body.data_length = len;
		ev.body.error_code = err;
		ev.stamp = stamp;
		ev.last = 1'b0;
		byte_events.push_back(ev);
	endfunction

	// Advances the parser state by one byte and queues the events it causes.
	function automatic int predict_events(input logic [7:0] b, input logic [63:0] stamp);
		logic [7:0] active;
		int         cnt;
		byte_events.delete();
		if (b >= SB_RT_MIN) begin
			emit(KIND_MSG, b, '0, '0, '0, '0, stamp);
		end else if (b == SB_SX_START) begin
			cur_status = b;
			run_status = '0;
			seen_count = '0;
			sysex_open = 1'b1;
			emit(KIND_SX_START, b, '0, '0, '0, '0, stamp);
		end else if (b == SB_SX_END) begin
			if (!sysex_open) begin
				clear_parse();
				emit(KIND_ERROR, '0, '0, '0, '0, ERR_END_NO_START, stamp);
			end else begin
				cur_status = '0;
				run_status = '0;
				seen_count = '0;
				sysex_open = 1'b0;
				emit(KIND_SX_END, b, '0, '0, '0, '0, stamp);
			end
		end else if (b[7]) begin
			if (sysex_open)
				emit(KIND_SX_ABORT, b, '0, '0, '0, '0, stamp);
			cur_status = b;
			run_status = (b <= SB_CHAN_MAX) ? b : 8'h00;
			seen_count = '0;
			sysex_open = 1'b0;
			if (b == SB_TUNE_REQ)
				emit(KIND_MSG, b, '0, '0, '0, '0, stamp);
		end else if (sysex_open) begin
			emit(KIND_SX_DATA, b, '0, '0, '0, '0, stamp);
		end else begin
			if (cur_status[7]) begin
				active = cur_status;
			end else if (run_status != 0) begin
				active = run_status;
			end else begin
				clear_parse();
				emit(KIND_ERROR, '0, '0, '0, '0, ERR_ORPHAN, stamp);
				active = '0;
			end
			// Statuses that take no data leave their data bytes unanswered.
			if (byte_events.size() == 0 && ((active >= 8'h80 && active <= SB_CHAN_MAX)
					|| (active >= SB_MTC && active <= SB_SONG_SEL))) begin
				cnt = seen_count + 1;
				if (cnt == 1) begin
					data_a = b[6:0];
				end else if (cnt == 2) begin
					data_b = b[6:0];
				end else begin
					clear_parse();
					emit(KIND_ERROR, '0, '0, '0, '0, ERR_UNEXPECTED, stamp);
				end
				if (byte_events.size() == 0) begin
					seen_count = cnt[1:0];
					if (cnt == msg_needed(active)) begin
						emit(KIND_MSG, active, data_a, data_b, cnt[1:0], '0, stamp);
						cur_status = '0;
						seen_count = '0;
						data_a = '0;
						data_b = '0;
					end
				end
			end
		end
		if (byte_events.size() != 0)
			byte_events[byte_events.size() - 1].last = 1'b1;
		foreach (byte_events[i])
			pending_events.push_back(byte_events[i]);
		return byte_events.size();
	endfunction

	function automatic logic [63:0] random_stamp();
		if ($urandom_range(0, 15) != 0)
			return {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7FFF_FFFF_FFFF_FFFF;
			2: return 64'h0;
			default: return '1;
		endcase
	endfunction

	function automatic void add_item(input logic [7:0] b, input logic [63:0] stamp);
		byte_item_t it;
		it.value = b;
		it.stamp = stamp;
		// Every fourth block of 64 items goes out back to back.
		it.gap = ((byte_items.size() / 64) % 4 == 0) ? 0 : $urandom_range(0, 5);
		it.drain = (byte_items.size() % 200 == 100);
		byte_items.push_back(it);
	endfunction

	// A data byte, now and then preceded by a real-time byte.
	function automatic void add_data(input logic [7:0] b);
		if ($urandom_range(0, 11) == 0)
			add_item(8'($urandom_range(SB_RT_MIN, 8'hFF)), random_stamp());
		add_item(b, random_stamp());
	endfunction

	function automatic void add_random_sequence();
		logic [7:0] st;
		int         pick;
		int         n;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			st = 8'($urandom_range(SB_STATUS_MIN, SB_CHAN_MAX));
			add_item(st, random_stamp());
			n = msg_needed(st);
			repeat ($urandom_range(1, 3))
				repeat (n)
					add_data(8'($urandom_range(0, 127)));
		end else if (pick < 65) begin
			add_item(SB_SX_START, random_stamp());
			repeat ($urandom_range(0, 8))
				add_data(8'($urandom_range(0, 127)));
			case ($urandom_range(0, 9))
				0: add_item(8'($urandom_range(SB_STATUS_MIN, SB_TUNE_REQ)),
					random_stamp());
				1: ;
				default: add_item(SB_SX_END, random_stamp());
			endcase
		end else if (pick < 80) begin
			st = 8'($urandom_range(SB_MTC, SB_TUNE_REQ));
			add_item(st, random_stamp());
			n = msg_needed(st);
			if (n == 0)
				n = $urandom_range(0, 2);
			repeat (n)
				add_data(8'($urandom_range(0, 127)));
		end else if (pick < 88) begin
			if ($urandom_range(0, 1) != 0)
				add_item(SB_SX_END, random_stamp());
			else
				add_data(8'($urandom_range(0, 127)));
		end else begin
			repeat ($urandom_range(1, 4))
				add_item(8'($urandom_range(0, 255)), random_stamp());
		end
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			failures++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.stream_byte = '0;
		byte_ch.time_stamp = '0;
		event_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: presents the queued bytes after their drawn gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			gap_cnt <= 0;
			predicted_n <= 0;
			clear_parse();
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				made_n = predict_events(byte_ch.stream_byte, byte_ch.time_stamp);
				predicted_n <= predicted_n + made_n;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				// A draining item waits in a gap until every event is back.
				if (byte_items.size() != 0 && gap_cnt >= byte_items[0].gap
						&& (!byte_items[0].drain
						|| (!byte_ch.valid && predicted_n == checked_n))) begin
					next_item = byte_items.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.stream_byte <= next_item.value;
					byte_ch.time_stamp <= next_item.stamp;
					gap_cnt <= 0;
				end else begin
					byte_ch.valid <= 1'b0;
					gap_cnt <= gap_cnt + 1;
				end
			end
		end
	end

	// Receiver: checks each event and draws the stall before the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			event_ch.ready <= 1'b0;
			stall_cnt <= 0;
			checked_n <= 0;
			cycle_n <= 0;
		end else begin
			cycle_n <= cycle_n + 1;
			if (event_ch.valid && event_ch.ready) begin
				checked_n <= checked_n + 1;
				if (pending_events.size() == 0) begin
					$error("event with none expected: kind %0d, byte %0h",
						event_ch.event_kind, event_ch.status_or_byte);
					failures++;
				end else begin
					want = pending_events.pop_front();
					check_field("event_kind", want.body.event_kind, event_ch.event_kind);
					check_field("status_or_byte", want.body.status_or_byte,
						event_ch.status_or_byte);
					check_field("data_one", want.body.data_one, event_ch.data_one);
					check_field("data_two", want.body.data_two, event_ch.data_two);
					check_field("data_length", want.body.data_length, event_ch.data_length);
					check_field("error_code", want.body.error_code, event_ch.error_code);
					check_field("time_out", want.stamp, event_ch.time_out);
					check_field("last_of_run", want.last, event_ch.last_of_run);
				end
				stall = ((cycle_n / 256) % 4 == 1) ? 0 : $urandom_range(0, 5);
				if (stall == 0) begin
					event_ch.ready <= 1'b1;
				end else begin
					event_ch.ready <= 1'b0;
					stall_cnt <= stall;
				end
			end else if (!event_ch.ready) begin
				if (stall_cnt <= 1)
					event_ch.ready <= 1'b1;
				stall_cnt <= stall_cnt - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n_directed;
		failures = 0;
		// Real-time bytes, a SysEx with extreme data and a real-time byte inside,
		// a stray end, an orphan data byte, running status, an abort by tune
		// request, data after a status that takes none, song position and
		// select, and an abort by a channel status.
		opening = '{8'hF8, 8'hF0, 8'h00, 8'hFF, 8'h7F, 8'hF7, 8'hF7, 8'h05,
			8'h90, 8'h3C, 8'h7F, 8'hC5, 8'h7F, 8'h12, 8'hF0, 8'h11, 8'hF6, 8'h33,
			8'hF4, 8'h22, 8'hF2, 8'h01, 8'h02, 8'hF3, 8'h7F, 8'hF0, 8'hE0, 8'h00,
			8'h7F};
		add_item(opening[0], 64'h8000_0000_0000_0000);
		add_item(opening[1], 64'h7FFF_FFFF_FFFF_FFFF);
		add_item(opening[2], 64'h0);
		add_item(opening[3], '1);
		for (int i = 4; i < opening.size(); i++)
			add_item(opening[i], random_stamp());
		n_directed = byte_items.size();
		while (byte_items.size() < n_directed + RANDOM_ITEMS)
			add_random_sequence();

		while (byte_items.size() != 0 || byte_ch.valid)
			@(negedge clk);
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/mbsp_pkg.sv
rtl/core/mbsp_byte_if.sv
rtl/core/mbsp_event_if.sv
rtl/core/mbsp_decode.sv
rtl/core/midi_byte_stream_parser_unit.sv
dv/tb_midi_byte_stream_parser_unit.sv
